[src/shlf_pkg.sv]
// Shared types and constants for the SIP header line framer.
`default_nettype none
package shlf_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EMPTY_NAME  = 3'd1;
    localparam logic [2:0] ST_NAME_BLANK  = 3'd2;
    localparam logic [2:0] ST_CR_NO_LF    = 3'd3;
    localparam logic [2:0] ST_NO_CRLF     = 3'd4;
    localparam logic [2:0] ST_NO_COLON    = 3'd5;

    typedef enum logic [2:0] {
        BC_OTHER,
        BC_BLANK,
        BC_COLON,
        BC_CR,
        BC_LF
    } byte_class_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        byte_class_t cls;
        logic        last_byte;
    } cls_item_t;

    typedef struct packed {
        logic [15:0] name_offset;
        logic [15:0] name_length;
        logic [15:0] value_offset;
        logic [15:0] value_length;
        logic        end_of_headers;
        logic [2:0]  status;
    } out_item_t;

endpackage
`default_nettype wire

[src/shlf_fifo.sv]
// Small register-based FIFO used as the queues of the framer.
`default_nettype none
module shlf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_C = AW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (AW + 1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (AW + 1)'(1);
            end
        end
    end
endmodule
`default_nettype wire

[src/shlf_front.sv]
// Front end: accepts bytes, classifies them and queues them for the framer.
`default_nettype none
module shlf_front #(
    parameter int DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire shlf_pkg::in_item_t  in_item,
    output logic                     full,
    input  wire logic                take,
    output shlf_pkg::cls_item_t      head,
    output logic                     empty
);
    localparam int W = $bits(shlf_pkg::cls_item_t);

    shlf_pkg::cls_item_t cls_item;
    logic [W-1:0]        head_bits;

    always_comb
    begin
        case (in_item.byte_value)
            shlf_pkg::CH_SPACE,
            shlf_pkg::CH_TAB:   cls_item.cls = shlf_pkg::BC_BLANK;
            shlf_pkg::CH_COLON: cls_item.cls = shlf_pkg::BC_COLON;
            shlf_pkg::CH_CR:    cls_item.cls = shlf_pkg::BC_CR;
            shlf_pkg::CH_LF:    cls_item.cls = shlf_pkg::BC_LF;
            default:            cls_item.cls = shlf_pkg::BC_OTHER;
        endcase
        cls_item.last_byte = in_item.last_byte;
    end

    shlf_fifo #(
        .WIDTH(W),
        .DEPTH(DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_data(W'(cls_item)),
        .full   (full),
        .rd_en  (take),
        .rd_data(head_bits),
        .empty  (empty)
    );

    assign head = shlf_pkg::cls_item_t'(head_bits);
endmodule
`default_nettype wire

[src/shlf_back.sv]
// Back end: header framing state machine over classified bytes.
`default_nettype none
module shlf_back #(
    parameter int MAX_MESSAGE_BYTES = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire shlf_pkg::cls_item_t  item,
    input  wire logic                 item_valid,
    output logic                      item_take,
    output shlf_pkg::out_item_t       res,
    output logic                      res_write,
    input  wire logic                 res_full
);
    localparam int PW = $clog2(MAX_MESSAGE_BYTES);
    localparam logic [PW:0] MOD = (PW + 1)'(MAX_MESSAGE_BYTES);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_MESSAGE_BYTES - 1);

    typedef enum logic [2:0] {
        PH_NAME,
        PH_VALUE,
        PH_WANT_LF,
        PH_AFTER_LF,
        PH_AFTER_CR,
        PH_PEND_EMPTY,
        PH_SKIP
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] hs_reg, hs_next;
    logic [PW-1:0] nbc_reg, nbc_next;
    logic [PW-1:0] held_reg, held_next;
    logic [PW-1:0] vs_reg, vs_next;
    logic          vl_reg, vl_next;
    logic [PW-1:0] le_reg, le_next;
    logic          step;
    logic          is_blank;
    logic          is_colon;
    logic          is_cr;
    logic          is_lf;

    function automatic logic [PW-1:0] pos_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[PW])
        begin
            d = d + MOD;
        end
        return d[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] a);
        return (a == POS_MAX) ? '0 : a + PW'(1);
    endfunction

    function automatic logic [15:0] to16(input logic [PW-1:0] v);
        logic [PW+15:0] w;
        w = (PW + 16)'(v);
        return w[15:0];
    endfunction

    assign step      = item_valid && !res_full;
    assign item_take = step;
    assign is_blank  = (item.cls == shlf_pkg::BC_BLANK);
    assign is_colon  = (item.cls == shlf_pkg::BC_COLON);
    assign is_cr     = (item.cls == shlf_pkg::BC_CR);
    assign is_lf     = (item.cls == shlf_pkg::BC_LF);

    always_comb
    begin
        logic          got;
        shlf_pkg::out_item_t r;
        got        = 1'b0;
        r          = '0;
        phase_next = phase_reg;
        hs_next    = hs_reg;
        nbc_next   = nbc_reg;
        held_next  = held_reg;
        vs_next    = vs_reg;
        vl_next    = vl_reg;
        le_next    = le_reg;
        pos_next   = pos_reg;

        case (phase_reg)
            PH_NAME:
            begin
                if (is_colon)
                begin
                    if (pos_reg == hs_reg)
                    begin
                        got = 1'b1;
                        r.name_offset = to16(hs_reg);
                        r.status = shlf_pkg::ST_EMPTY_NAME;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        held_next  = pos_sub(pos_sub(pos_reg, hs_reg), nbc_reg);
                        vl_next    = 1'b1;
                        phase_next = PH_VALUE;
                    end
                end
                else if (is_blank)
                begin
                    nbc_next = pos_inc(nbc_reg);
                end
                else if (nbc_reg != '0)
                begin
                    got = 1'b1;
                    r.name_offset = to16(hs_reg);
                    r.status = shlf_pkg::ST_NAME_BLANK;
                    phase_next = PH_SKIP;
                end
            end
            PH_VALUE:
            begin
                if (!(vl_reg && is_blank))
                begin
                    if (vl_reg)
                    begin
                        vs_next = pos_reg;
                        vl_next = 1'b0;
                    end
                    if (is_cr)
                    begin
                        le_next    = pos_reg;
                        phase_next = PH_WANT_LF;
                    end
                end
            end
            PH_WANT_LF:
            begin
                if (!is_lf)
                begin
                    got = 1'b1;
                    r.name_offset = to16(hs_reg);
                    r.status = shlf_pkg::ST_CR_NO_LF;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    phase_next = PH_AFTER_LF;
                end
            end
            PH_AFTER_LF:
            begin
                if (item.last_byte)
                begin
                    got = 1'b1;
                    r.name_offset = to16(hs_reg);
                    r.status = shlf_pkg::ST_NO_CRLF;
                    phase_next = PH_SKIP;
                end
                else if (is_blank)
                begin
                    phase_next = PH_VALUE;
                end
                else if (is_cr)
                begin
                    phase_next = PH_AFTER_CR;
                end
                else
                begin
                    got = 1'b1;
                    r.name_offset  = to16(hs_reg);
                    r.name_length  = to16(held_reg);
                    r.value_offset = to16(vs_reg);
                    r.value_length = to16(pos_sub(le_reg, vs_reg));
                    r.status       = shlf_pkg::ST_OK;
                    hs_next    = pos_reg;
                    nbc_next   = '0;
                    phase_next = is_colon ? PH_PEND_EMPTY : PH_NAME;
                end
            end
            PH_AFTER_CR:
            begin
                got = 1'b1;
                r.name_offset  = to16(hs_reg);
                r.name_length  = to16(held_reg);
                r.value_offset = to16(vs_reg);
                r.value_length = to16(pos_sub(le_reg, vs_reg));
                r.status       = shlf_pkg::ST_OK;
                if (is_lf)
                begin
                    r.end_of_headers = 1'b1;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    // new header began at the lone CR
                    hs_next    = pos_sub(pos_reg, PW'(1));
                    nbc_next   = '0;
                    phase_next = PH_NAME;
                    if (is_colon)
                    begin
                        held_next  = PW'(1);
                        vl_next    = 1'b1;
                        phase_next = PH_VALUE;
                    end
                    else if (is_blank)
                    begin
                        nbc_next = PW'(1);
                    end
                end
            end
            PH_PEND_EMPTY:
            begin
                got = 1'b1;
                r.name_offset = to16(hs_reg);
                r.status = shlf_pkg::ST_EMPTY_NAME;
                phase_next = PH_SKIP;
            end
            default:
            begin
                phase_next = PH_SKIP;
            end
        endcase

        if (item.last_byte)
        begin
            if (!got)
            begin
                if (phase_next == PH_NAME)
                begin
                    got = 1'b1;
                    r = '0;
                    r.name_offset = to16(hs_next);
                    r.status = shlf_pkg::ST_NO_COLON;
                end
                else if (phase_next inside {PH_VALUE, PH_WANT_LF, PH_AFTER_LF})
                begin
                    got = 1'b1;
                    r = '0;
                    r.name_offset = to16(hs_next);
                    r.status = shlf_pkg::ST_NO_CRLF;
                end
            end
            phase_next = PH_NAME;
            pos_next   = '0;
            hs_next    = '0;
            nbc_next   = '0;
            held_next  = '0;
            vs_next    = '0;
            vl_next    = 1'b1;
            le_next    = '0;
        end
        else
        begin
            pos_next = pos_inc(pos_reg);
        end

        res       = r;
        res_write = step && got;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NAME;
            pos_reg   <= '0;
            hs_reg    <= '0;
            nbc_reg   <= '0;
            held_reg  <= '0;
            vs_reg    <= '0;
            vl_reg    <= 1'b1;
            le_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hs_reg    <= hs_next;
            nbc_reg   <= nbc_next;
            held_reg  <= held_next;
            vs_reg    <= vs_next;
            vl_reg    <= vl_next;
            le_reg    <= le_next;
        end
    end
endmodule
`default_nettype wire

[src/sip_header_line_framer.sv]
// Top level of the SIP header line framer.
//
//   channel   direction  handshake          payload
//   input     in         push / full        in_item  (byte_value, last_byte)
//   result    out        pop / empty        out_item (offsets, lengths, flags, status)
//
// The state machine takes one queued byte a cycle while the result queue has room.
// A result enters the result queue when its causing byte leaves the input queue.
// Reset clears both queues and returns the framer to the start of a header.
// A full result queue stalls the framer; the input queue then fills and raises full.
`default_nettype none
module sip_header_line_framer #(
    parameter int MAX_MESSAGE_BYTES = 65536,
    parameter int IN_QUEUE_DEPTH    = 4,
    parameter int OUT_QUEUE_DEPTH   = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire shlf_pkg::in_item_t  in_item,
    output logic                     full,
    input  wire logic                pop,
    output shlf_pkg::out_item_t      out_item,
    output logic                     empty
);
    localparam int OW = $bits(shlf_pkg::out_item_t);

    shlf_pkg::cls_item_t head;
    logic                head_empty;
    logic                head_take;
    shlf_pkg::out_item_t res;
    logic                res_write;
    logic                res_full;
    logic [OW-1:0]       out_bits;

    shlf_front #(
        .DEPTH(IN_QUEUE_DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .in_item(in_item),
        .full   (full),
        .take   (head_take),
        .head   (head),
        .empty  (head_empty)
    );

    shlf_back #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (head),
        .item_valid(!head_empty),
        .item_take (head_take),
        .res       (res),
        .res_write (res_write),
        .res_full  (res_full)
    );

    shlf_fifo #(
        .WIDTH(OW),
        .DEPTH(OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_write),
        .wr_data(OW'(res)),
        .full   (res_full),
        .rd_en  (pop),
        .rd_data(out_bits),
        .empty  (empty)
    );

    assign out_item = shlf_pkg::out_item_t'(out_bits);
endmodule
`default_nettype wire

[tb/sip_header_line_framer_tb.sv]
// Testbench for sip_header_line_framer: directed and random SIP header sections checked against a predictor.
`timescale 1ns / 1ps
module sip_header_line_framer_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int ITEMS_PER_PASS = 433;

    typedef enum logic [2:0] {
        FR_NAME,
        FR_VALUE,
        FR_WANT_LF,
        FR_AFTER_LF,
        FR_AFTER_CR,
        FR_PEND_EMPTY,
        FR_SKIP
    } framer_phase_t;

    class header_checker;
        shlf_pkg::out_item_t pending_headers[$];
        int unsigned         errors;
        framer_phase_t       ph;
        logic [15:0]         pos;
        logic [15:0]         hdr_start;
        logic [15:0]         blank_cnt;
        logic [15:0]         name_len;
        logic [15:0]         val_start;
        logic [15:0]         line_end;
        bit                  val_lead;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            ph        = FR_NAME;
            pos       = '0;
            hdr_start = '0;
            blank_cnt = '0;
            name_len  = '0;
            val_start = '0;
            line_end  = '0;
            val_lead  = 1'b1;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == shlf_pkg::CH_SPACE || b == shlf_pkg::CH_TAB;
        endfunction

        function void fail_item(logic [2:0] code, bit emit);
            shlf_pkg::out_item_t r;
            r                = '0;
            r.name_offset    = hdr_start;
            r.status         = code;
            if (emit)
                pending_headers.push_back(r);
            ph = FR_SKIP;
        endfunction

        function void header_item(bit eoh);
            shlf_pkg::out_item_t r;
            r.name_offset    = hdr_start;
            r.name_length    = name_len;
            r.value_offset   = val_start;
            r.value_length   = line_end - val_start;
            r.end_of_headers = eoh;
            r.status         = shlf_pkg::ST_OK;
            pending_headers.push_back(r);
        endfunction

        function void start_header(logic [15:0] p);
            hdr_start = p;
            blank_cnt = '0;
            ph        = FR_NAME;
        endfunction

        function bit name_step(logic [7:0] b, logic [15:0] p, bit emit);
            if (b == shlf_pkg::CH_COLON)
            begin
                if (p == hdr_start)
                begin
                    fail_item(shlf_pkg::ST_EMPTY_NAME, emit);
                    return 1'b1;
                end
                name_len = p - hdr_start - blank_cnt;
                val_lead = 1'b1;
                ph       = FR_VALUE;
                return 1'b0;
            end
            if (is_blank(b))
            begin
                blank_cnt = blank_cnt + 16'd1;
                return 1'b0;
            end
            if (blank_cnt != 0)
            begin
                fail_item(shlf_pkg::ST_NAME_BLANK, emit);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(shlf_pkg::in_item_t it);
            logic [7:0]  b;
            logic [15:0] p;
            bit          lst;
            bit          gave;
            b    = it.byte_value;
            lst  = it.last_byte;
            p    = pos;
            gave = 1'b0;
            case (ph)
                FR_NAME:
                    gave = name_step(b, p, 1'b1);
                FR_VALUE:
                begin
                    if (!(val_lead && is_blank(b)))
                    begin
                        if (val_lead)
                        begin
                            val_start = p;
                            val_lead  = 1'b0;
                        end
                        if (b == shlf_pkg::CH_CR)
                        begin
                            line_end = p;
                            ph       = FR_WANT_LF;
                        end
                    end
                end
                FR_WANT_LF:
                begin
                    if (b != shlf_pkg::CH_LF)
                    begin
                        fail_item(shlf_pkg::ST_CR_NO_LF, 1'b1);
                        gave = 1'b1;
                    end
                    else
                        ph = FR_AFTER_LF;
                end
                FR_AFTER_LF:
                begin
                    if (lst)
                    begin
                        fail_item(shlf_pkg::ST_NO_CRLF, 1'b1);
                        gave = 1'b1;
                    end
                    else if (is_blank(b))
                        ph = FR_VALUE;
                    else if (b == shlf_pkg::CH_CR)
                        ph = FR_AFTER_CR;
                    else
                    begin
                        header_item(1'b0);
                        gave = 1'b1;
                        start_header(p);
                        if (b == shlf_pkg::CH_COLON)
                            ph = FR_PEND_EMPTY;
                    end
                end
                FR_AFTER_CR:
                begin
                    header_item(b == shlf_pkg::CH_LF);
                    gave = 1'b1;
                    if (b == shlf_pkg::CH_LF)
                        ph = FR_SKIP;
                    else
                    begin
                        // the CR opens the next header's name
                        start_header(p - 16'd1);
                        void'(name_step(b, p, 1'b0));
                    end
                end
                FR_PEND_EMPTY:
                begin
                    fail_item(shlf_pkg::ST_EMPTY_NAME, 1'b1);
                    gave = 1'b1;
                end
                default:
                    ph = FR_SKIP;
            endcase
            if (lst)
            begin
                if (!gave)
                begin
                    if (ph == FR_NAME)
                        fail_item(shlf_pkg::ST_NO_COLON, 1'b1);
                    else if (ph == FR_VALUE || ph == FR_WANT_LF || ph == FR_AFTER_LF)
                        fail_item(shlf_pkg::ST_NO_CRLF, 1'b1);
                end
                clear();
            end
            else
                pos = p + 16'd1;
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        function void check_result(shlf_pkg::out_item_t got);
            shlf_pkg::out_item_t want;
            if (pending_headers.size() == 0)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = pending_headers.pop_front();
            compare_field("name_offset", 32'(want.name_offset), 32'(got.name_offset));
            compare_field("name_length", 32'(want.name_length), 32'(got.name_length));
            compare_field("value_offset", 32'(want.value_offset), 32'(got.value_offset));
            compare_field("value_length", 32'(want.value_length), 32'(got.value_length));
            compare_field("end_of_headers", 32'(want.end_of_headers),
                          32'(got.end_of_headers));
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction

        function int pending();
            return pending_headers.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic                pop;
    logic                empty;
    shlf_pkg::in_item_t  in_item;
    shlf_pkg::out_item_t out_item;

    header_checker       sb;
    shlf_pkg::in_item_t  msg[$];
    int                  sent          = 0;
    int                  send_idle_pct = 0;
    int                  rx_stall_pct  = 0;
    bit                  hold_request  = 1'b0;

    sip_header_line_framer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_item  (in_item),
        .full     (full),
        .pop      (pop),
        .out_item (out_item),
        .empty    (empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] rand_blank();
        return $urandom_range(0, 1) ? shlf_pkg::CH_SPACE : shlf_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        c = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(32, 126));
        if (c == shlf_pkg::CH_CR)
            c = shlf_pkg::CH_LF;
        return c;
    endfunction

    task automatic add_byte(logic [7:0] b);
        shlf_pkg::in_item_t it;
        it.byte_value = b;
        it.last_byte  = 1'b0;
        msg.push_back(it);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic send_request(shlf_pkg::in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            push = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        push    = 1'b1;
        in_item = it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_byte(it);
        sent++;
    endtask

    task automatic send_msg();
        msg[$].last_byte = 1'b1;
        foreach (msg[i])
            send_request(msg[i]);
        msg.delete();
    endtask

    task automatic drain();
        @(negedge clk);
        push = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic gen_random_message();
        int k;
        int cut;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
        else
        begin
            repeat ($urandom_range(0, 4))
            begin
                k = int'($urandom_range(0, 19));
                if (k == 1)
                    repeat ($urandom_range(1, 2)) add_byte(rand_blank());
                else if (k != 0)
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        add_byte(8'($urandom_range(33, 126)));
                        if (msg[$].byte_value == shlf_pkg::CH_COLON)
                            msg[$].byte_value = "-";
                    end
                    if (k == 2)
                    begin
                        add_byte(rand_blank());
                        add_byte("x");
                    end
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 2)) add_byte(rand_blank());
                end
                add_byte(shlf_pkg::CH_COLON);
                repeat ($urandom_range(0, 2)) add_byte(rand_blank());
                repeat ($urandom_range(0, 8)) add_byte(value_char());
                while ($urandom_range(0, 4) == 0)
                begin
                    add_text("\r\n");
                    repeat ($urandom_range(1, 2)) add_byte(rand_blank());
                    repeat ($urandom_range(0, 8)) add_byte(value_char());
                end
                add_text("\r\n");
            end
            if ($urandom_range(0, 6) != 0)
            begin
                add_text("\r\n");
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            end
            if (msg.size() > 0 && $urandom_range(0, 6) == 0)
                msg[$urandom_range(0, msg.size() - 1)].byte_value = 8'($urandom_range(0, 255));
            if (msg.size() > 1 && $urandom_range(0, 9) == 0)
            begin
                cut = int'($urandom_range(1, msg.size() - 1));
                while (msg.size() > cut)
                    void'(msg.pop_back());
            end
        end
        if (msg.size() == 0)
            add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic random_pass(int sender_pct, int receiver_pct);
        int target;
        target        = sent + ITEMS_PER_PASS;
        send_idle_pct = sender_pct;
        rx_stall_pct  = receiver_pct;
        while (sent < target)
        begin
            gen_random_message();
            send_msg();
        end
    endtask

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                pop          = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            pop = ($urandom_range(0, 99) >= rx_stall_pct);
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result(out_item);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("sip_header_line_framer_tb: FAIL");
        $finish;
    end

    initial
    begin
        push    = 1'b0;
        in_item = '0;
        rst_n   = 1'b0;
        sb      = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // folded value, leading blanks, end of headers
        add_text("a: b\r\n\tc\r\n\r\n");
        send_msg();
        // blank-only name, CR LF with no bytes after it
        add_text(" :x\r\n");
        send_msg();
        add_text(":");
        send_msg();
        add_byte(8'hFF);
        add_byte(shlf_pkg::CH_SPACE);
        add_byte(8'h00);
        send_msg();
        add_text("a:\r");
        add_byte(8'h80);
        send_msg();
        add_text("q");
        send_msg();

        random_pass(15, 64);
        drain();
        random_pass(64, 15);
        drain();

        hold_request = 1'b1;
        random_pass(0, 0);

        drain();
        if (sb.errors == 0)
            $display("sip_header_line_framer_tb: PASS");
        else
            $display("sip_header_line_framer_tb: FAIL");
        $finish;
    end
endmodule

[sim.f]
src/shlf_pkg.sv
src/shlf_fifo.sv
src/shlf_front.sv
src/shlf_back.sv
src/sip_header_line_framer.sv
tb/sip_header_line_framer_tb.sv
